/* src/fblr_pkg.sv */
// Shared types and codes for the framebuffer line rasterizer.
// Used by the controller, the datapath, the top level and the checker.
package fblr_pkg;

  // Operation codes carried by the in_operation port
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_LINE  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  // Configuration register indexes
  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  // Fixed field widths
  localparam int COORD_W = 12;
  localparam int DIM_W   = 7;
  localparam int DATA_W  = 32;
  localparam int ERR_W   = 14;

  // Reset value of both area registers
  localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // capture request fields
    logic clear_wr;    // write zero at the clear counter
    logic pix_wr;      // write the request value at the current point
    logic rd_issue;    // present the current point to the read port
    logic rd_capture;  // take read data into the result
    logic line_init;   // start the error term
    logic line_step;   // plot the current point and advance
    logic out_load;    // move the result into the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;    // clear counter is at the last entry
    logic at_end;      // current point equals the line end point
    op_t  op;          // operation of the request in flight
  } status_t;

endpackage

/* src/framebuffer_line_rasterizer_core.sv */
// Framebuffer line rasterizer: pixel write, pixel read and line draw requests
// over a row-major store. Depends on fblr_pkg, fblr_ctrl and fblr_dp.
//
// After reset the block clears its store, one entry per cycle, over all
// MAX_ROWS*MAX_COLS entries (4096 at the default size); in_ready stays low
// meanwhile, while configuration writes are taken at any time. Requests are
// handled one at a time. A write or an unknown operation goes through the
// EXEC and FINISH states, a read through EXEC, RDATA and FINISH (the store has
// a registered read port), and a line through EXEC, LINE and FINISH. A line
// has N = max(|row_b-row_a|, |col_b-col_a|)+1 pixels; the line walker plots
// one pixel per cycle through the single store write port. The next request
// can be taken once a result is registered, even while it waits for out_ready.
// Every request returns exactly one result; only reads give a nonzero value.
module framebuffer_line_rasterizer_core
  import fblr_pkg::*;
#(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int PIXEL_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [DIM_W-1:0]          cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_operation,
  input  logic signed [COORD_W-1:0] in_row_a,
  input  logic signed [COORD_W-1:0] in_col_a,
  input  logic signed [COORD_W-1:0] in_row_b,
  input  logic signed [COORD_W-1:0] in_col_b,
  input  logic [DATA_W-1:0]         in_pixel_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [DATA_W-1:0]         out_read_value
);

  cmd_t    cmd;
  status_t sts;

  // Registers take every write
  assign cfg_ready = 1'b1;

  fblr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fblr_dp #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_operation   (in_operation),
    .in_row_a       (in_row_a),
    .in_col_a       (in_col_a),
    .in_row_b       (in_row_b),
    .in_col_b       (in_col_b),
    .in_pixel_value (in_pixel_value),
    .out_read_value (out_read_value)
  );

endmodule

/* src/fblr_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module fblr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/fblr_ctrl.sv */
// Controller state machine of the framebuffer line rasterizer.
// Depends on fblr_pkg for the command, status and operation types.
module fblr_ctrl
  import fblr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t sts,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_LINE,
    S_RDATA,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Decode commands and next state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts.op)
          OP_WRITE: begin
            cmd.pix_wr = 1'b1;
            state_nxt  = S_FINISH;
          end
          OP_READ: begin
            cmd.rd_issue = 1'b1;
            state_nxt    = S_RDATA;
          end
          OP_LINE: begin
            cmd.line_init = 1'b1;
            state_nxt     = S_LINE;
          end
          default: begin
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_LINE: begin
        cmd.line_step = 1'b1;
        if (sts.at_end) begin
          state_nxt = S_FINISH;
        end
      end
      S_RDATA: begin
        cmd.rd_capture = 1'b1;
        state_nxt      = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = cmd.out_load | (out_valid_r & ~out_ready);
  end

  // Hold state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* src/fblr_dp.sv */
// Datapath of the framebuffer line rasterizer: area registers, line stepper,
// address generation and the pixel store. Depends on fblr_pkg and fblr_ram.
module fblr_dp
  import fblr_pkg::*;
#(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int PIXEL_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cmd_t                      cmd,
  output status_t                   sts,
  input  logic                      cfg_valid,
  input  logic                      cfg_index,
  input  logic [DIM_W-1:0]          cfg_data,
  input  logic [1:0]                in_operation,
  input  logic signed [COORD_W-1:0] in_row_a,
  input  logic signed [COORD_W-1:0] in_col_a,
  input  logic signed [COORD_W-1:0] in_row_b,
  input  logic signed [COORD_W-1:0] in_col_b,
  input  logic [DATA_W-1:0]         in_pixel_value,
  output logic [DATA_W-1:0]         out_read_value
);

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = $clog2(DEPTH > 1 ? DEPTH : 2);
  localparam int LIN_W  = 2 * DIM_W;
  localparam int CAP_W  = 11;
  localparam logic [CAP_W-1:0] ROW_CAP = CAP_W'(MAX_ROWS);
  localparam logic [CAP_W-1:0] COL_CAP = CAP_W'(MAX_COLS);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  logic [DIM_W-1:0]          rows_r, cols_r;
  op_t                       op_r;
  logic signed [COORD_W-1:0] r0_r, c0_r, r1_r, c1_r;
  logic [COORD_W-1:0]        dr_r, dc_r;
  logic                      row_up_r, col_up_r;
  logic signed [ERR_W-1:0]   err_r;
  logic [PIXEL_BITS-1:0]     val_r;
  logic [PIXEL_BITS-1:0]     res_r;
  logic [DATA_W-1:0]         out_r;
  logic [ADDR_W-1:0]         clr_cnt_r;
  logic                      rd_hit_r;

  logic [DIM_W-1:0]          eff_rows, eff_cols;
  logic                      in_area;
  logic [LIN_W-1:0]          lin;
  logic [ADDR_W-1:0]         pt_addr;
  logic signed [COORD_W:0]   d_row, d_col;
  logic [COORD_W-1:0]        abs_row, abs_col;
  logic signed [ERR_W-1:0]   dr_s, dc_s, err_nxt;
  logic                      mv_row, mv_col, at_end;
  logic                      mem_we;
  logic [ADDR_W-1:0]         mem_waddr;
  logic [PIXEL_BITS-1:0]     mem_wdata, mem_rdata;

  // Clamp the area to the store size
  assign eff_rows = ({4'b0, rows_r} > ROW_CAP) ? DIM_W'(MAX_ROWS) : rows_r;
  assign eff_cols = ({4'b0, cols_r} > COL_CAP) ? DIM_W'(MAX_COLS) : cols_r;

  // Area check and row-major address of the current point
  assign in_area = !r0_r[COORD_W-1] && !c0_r[COORD_W-1]
                && (r0_r[COORD_W-2:0] < {4'b0, eff_rows})
                && (c0_r[COORD_W-2:0] < {4'b0, eff_cols});
  assign lin     = r0_r[DIM_W-1:0] * eff_cols + LIN_W'(c0_r[DIM_W-1:0]);
  assign pt_addr = ADDR_W'(lin);

  // Spans of a new line request
  assign d_row   = $signed({in_row_b[COORD_W-1], in_row_b})
                 - $signed({in_row_a[COORD_W-1], in_row_a});
  assign d_col   = $signed({in_col_b[COORD_W-1], in_col_b})
                 - $signed({in_col_a[COORD_W-1], in_col_a});
  assign abs_row = d_row[COORD_W] ? COORD_W'(-d_row) : d_row[COORD_W-1:0];
  assign abs_col = d_col[COORD_W] ? COORD_W'(-d_col) : d_col[COORD_W-1:0];

  // One Bresenham step
  assign dr_s    = $signed({2'b00, dr_r});
  assign dc_s    = $signed({2'b00, dc_r});
  assign mv_row  = err_r > -dr_s;
  assign mv_col  = err_r < dc_s;
  assign err_nxt = err_r - (mv_row ? dc_s : '0) + (mv_col ? dr_s : '0);
  assign at_end  = (r0_r == r1_r) && (c0_r == c1_r);

  // Area registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= DIM_RESET;
      cols_r <= DIM_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_ROWS) begin
        rows_r <= cfg_data;
      end else begin
        cols_r <= cfg_data;
      end
    end
  end

  // Clear counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear_wr) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // Request fields, line walker and result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= op_t'(in_operation);
      r0_r     <= in_row_a;
      c0_r     <= in_col_a;
      r1_r     <= in_row_b;
      c1_r     <= in_col_b;
      val_r    <= in_pixel_value[PIXEL_BITS-1:0];
      dr_r     <= abs_row;
      dc_r     <= abs_col;
      row_up_r <= in_row_a < in_row_b;
      col_up_r <= in_col_a < in_col_b;
      res_r    <= '0;
    end
    if (cmd.line_init) begin
      err_r <= (dr_r > dc_r) ? $signed({3'b000, dr_r[COORD_W-1:1]})
                             : -$signed({3'b000, dc_r[COORD_W-1:1]});
    end
    if (cmd.line_step && !at_end) begin
      err_r <= err_nxt;
      if (mv_row) begin
        r0_r <= row_up_r ? r0_r + 1'b1 : r0_r - 1'b1;
      end
      if (mv_col) begin
        c0_r <= col_up_r ? c0_r + 1'b1 : c0_r - 1'b1;
      end
    end
    if (cmd.rd_issue) begin
      rd_hit_r <= in_area;
    end
    if (cmd.rd_capture) begin
      res_r <= rd_hit_r ? mem_rdata : '0;
    end
    if (cmd.out_load) begin
      out_r <= DATA_W'(res_r);
    end
  end

  // Store write port: clearing pass or plotted pixel
  assign mem_we    = cmd.clear_wr | ((cmd.pix_wr | cmd.line_step) & in_area);
  assign mem_waddr = cmd.clear_wr ? clr_cnt_r : pt_addr;
  assign mem_wdata = cmd.clear_wr ? '0 : val_r;

  fblr_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (pt_addr),
    .rdata (mem_rdata)
  );

  assign sts.clr_last  = (clr_cnt_r == LAST_ADDR);
  assign sts.at_end    = at_end;
  assign sts.op        = op_r;
  assign out_read_value = out_r;

endmodule

/* src/fblr_checker.sv */
// Port-level checks for the framebuffer line rasterizer, bound to the top level.
// Depends on fblr_pkg for field widths.
module fblr_checker
  import fblr_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              cfg_ready,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] out_read_value
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_value))
    else $error("stalled result changed or dropped");

  // One request at a time: no second accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in flight");

  // A result does not rise immediately after its request is accepted
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early");

  // Configuration writes are never stalled
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port stalled");

endmodule

bind framebuffer_line_rasterizer_core fblr_checker u_fblr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .cfg_ready      (cfg_ready),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_read_value (out_read_value)
);
